[rtl/lbrf_pkg.sv]
// shared types and constants for the learning bridge and route forwarder
// no dependencies
package lbrf_pkg;

  localparam int PEER_W = 4;
  localparam int MAC_W = 48;
  localparam int IP_W = 32;
  localparam int GROUP_BIT = 40;
  localparam logic [15:0] L2_HDR_LEN = 16'd14;
  localparam logic [15:0] L3_HDR_LEN = 16'd20;
  localparam logic [15:0] SRC_MAC_END = 16'd12;
  localparam logic [3:0] IPV4_VER = 4'h4;

  typedef enum logic [2:0] {
    KIND_OUTBOUND,
    KIND_INBOUND,
    KIND_SET_ROUTE,
    KIND_DEL_ROUTE,
    KIND_ADD_PEER,
    KIND_DEL_PEER,
    KIND_CLEAR
  } kind_t;

  typedef enum logic [1:0] {
    ACT_DROP,
    ACT_UNICAST,
    ACT_FLOOD,
    ACT_LOCAL
  } action_t;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_REMOVE,
    OP_PURGE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] frame_length;
    logic [7:0]  first_byte;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [31:0] ip_addr;
    logic [3:0]  peer_index;
    logic        peer_present;
  } in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  out_peer;
    logic [15:0] flood_mask;
    logic        table_full;
  } out_t;

  typedef struct packed {
    cell_op_t          op;
    logic              clear;
    logic              hit_known;
    logic [PEER_W-1:0] peer;
  } cell_ctl_t;

  typedef struct packed {
    logic              act;
    logic              hit;
    logic              claimed;
    logic [PEER_W-1:0] peer;
  } cell_tok_t;

endpackage

[rtl/lbrf_cell.sv]
// one table entry with its slice of the scan token path
// depends on lbrf_pkg
module lbrf_cell #(
  parameter int KEY_W = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lbrf_pkg::cell_ctl_t ctl,
  input  logic [KEY_W-1:0]    key,
  input  lbrf_pkg::cell_tok_t tok_in,
  output lbrf_pkg::cell_tok_t tok_out
);
  import lbrf_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [KEY_W-1:0]      key_r;
  logic [PEER_W-1:0]     peer_r;
  cell_tok_t             tok_r, tok_nxt;
  logic                  match, wr, kill;

  always_comb begin
    match = valid_r && (key_r == key);
    wr = tok_in.act && (ctl.op == OP_INSERT) &&
         (ctl.hit_known ? match : (!valid_r && !tok_in.claimed));
    kill = tok_in.act && (((ctl.op == OP_REMOVE) && match) ||
           ((ctl.op == OP_PURGE) && valid_r && (peer_r == ctl.peer)));
    tok_nxt = tok_in;
    if (tok_in.act && (ctl.op == OP_LOOKUP) && match && !tok_in.hit) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.peer = peer_r;
    end
    tok_nxt.claimed = tok_in.claimed | wr;
    if (ctl.clear) valid_nxt = 1'b0;
    else if (wr) valid_nxt = 1'b1;
    else if (kill) valid_nxt = 1'b0;
    else valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key_r <= key;
      peer_r <= ctl.peer;
    end
  end

  assign tok_out = tok_r;

endmodule

[rtl/lbrf_chain.sv]
// row of table cells; the scan token steps one cell per cycle
// depends on lbrf_pkg and lbrf_cell
module lbrf_chain #(
  parameter int ENTRIES = 64,
  parameter int KEY_W = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lbrf_pkg::cell_ctl_t ctl,
  input  logic                launch,
  input  logic [KEY_W-1:0]    key,
  output lbrf_pkg::cell_tok_t tok_out
);
  import lbrf_pkg::*;

  cell_tok_t tok [0:ENTRIES];

  assign tok[0] = '{act: launch, hit: 1'b0, claimed: 1'b0, peer: '0};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lbrf_cell #(.KEY_W(KEY_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .key    (key),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  assign tok_out = tok[ENTRIES];

endmodule

[rtl/learning_bridge_and_route_forwarder.sv]
// learning bridge / route forwarder: one result word per input word
// words decided at once (add peer, clear, short or group frames, no-op words) get their result
// registered straight from the decode; a lookup, remove or purge walks the token once down the
// chain, and a learn or set route walks it twice (find pass then fill pass)
// one word at a time: busy stays high while the token walks the cell chain, so the next word
// can be taken in the strobe cycle; words decided at once can follow every cycle
// synchronous active-low reset empties both tables and the peer set; the receiver cannot stall
module learning_bridge_and_route_forwarder #(
  parameter int MAC_ENTRIES = 64,
  parameter int ROUTE_ENTRIES = 64,
  parameter int PEER_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           start,
  output logic           busy,
  input  lbrf_pkg::in_t  in_word,
  output logic           out_valid,
  output lbrf_pkg::out_t out_word
);
  import lbrf_pkg::*;

  // peer indexes are 4 bits wide, so at most 16 bits of the set can ever be used
  localparam int SET_W = (PEER_SLOTS < 16) ? PEER_SLOTS : 16;

  state_t            state_r, state_nxt;
  logic              layer2_r;
  logic [SET_W-1:0]  peer_set_r, peer_set_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_word_r, out_word_nxt;
  logic              launch_r, launch_nxt;
  logic              sel_mac_r, sel_mac_nxt;
  logic              ins_r, ins_nxt;
  cell_op_t          op_r, op_nxt;
  logic              hit_known_r, hit_known_nxt;
  logic [MAC_W-1:0]  mac_key_r, mac_key_nxt;
  logic [IP_W-1:0]   route_key_r, route_key_nxt;
  logic [PEER_W-1:0] peer_q_r, peer_q_nxt;

  logic              accept, has_peer, done;
  logic              d_go, d_sel_mac, d_ins, d_imm;
  cell_op_t          d_op;
  out_t              d_res;
  logic [15:0]       flood;
  cell_ctl_t         ctl;
  cell_tok_t         mac_tok, route_tok, tok;

  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign has_peer = in_word.peer_present && (32'(in_word.peer_index) < PEER_SLOTS);
  assign flood = 16'(peer_set_r);

  assign ctl = '{op: op_r, clear: accept && (in_word.kind == KIND_CLEAR),
                 hit_known: hit_known_r, peer: peer_q_r};

  // cell chains: the MAC table and the route table
  lbrf_chain #(.ENTRIES(MAC_ENTRIES), .KEY_W(MAC_W)) u_mac_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .launch (launch_r && sel_mac_r),
    .key    (mac_key_r),
    .tok_out(mac_tok)
  );

  lbrf_chain #(.ENTRIES(ROUTE_ENTRIES), .KEY_W(IP_W)) u_route_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .launch (launch_r && !sel_mac_r),
    .key    (route_key_r),
    .tok_out(route_tok)
  );

  assign tok = sel_mac_r ? mac_tok : route_tok;
  assign done = tok.act;

  // decode the offered word: settle it at once or start a chain scan
  always_comb begin
    d_go = 1'b0;
    d_sel_mac = 1'b0;
    d_ins = 1'b0;
    d_op = OP_LOOKUP;
    d_imm = 1'b1;
    d_res = '0;
    unique case (in_word.kind)
      KIND_OUTBOUND: begin
        if (layer2_r) begin
          if (in_word.frame_length < L2_HDR_LEN) begin
            d_res.action = ACT_DROP;
          end else if (in_word.dest_mac[GROUP_BIT]) begin
            // group and broadcast frames flood without a lookup
            d_res.action = ACT_FLOOD;
            d_res.flood_mask = flood;
          end else begin
            d_go = 1'b1;
            d_sel_mac = 1'b1;
          end
        end else if ((in_word.frame_length >= L3_HDR_LEN) &&
                     (in_word.first_byte[7:4] == IPV4_VER)) begin
          d_go = 1'b1;
        end
      end
      KIND_INBOUND: begin
        d_res.action = ACT_LOCAL;
        if (layer2_r && (in_word.frame_length >= SRC_MAC_END) && has_peer) begin
          d_go = 1'b1;
          d_sel_mac = 1'b1;
          d_ins = 1'b1;
        end
      end
      KIND_SET_ROUTE: begin
        if ((in_word.ip_addr != '0) && has_peer) begin
          d_go = 1'b1;
          d_ins = 1'b1;
        end
      end
      KIND_DEL_ROUTE: begin
        d_go = 1'b1;
        d_op = OP_REMOVE;
      end
      KIND_DEL_PEER: begin
        if (has_peer) begin
          d_go = 1'b1;
          d_sel_mac = 1'b1;
          d_op = OP_PURGE;
        end
      end
      default: begin
      end
    endcase
    if (d_go) d_imm = 1'b0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && d_go) state_nxt = ST_SCAN;
      ST_SCAN: if (done) state_nxt = ins_r ? ST_FILL : ST_IDLE;
      ST_FILL: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result updates
  always_comb begin
    out_valid_nxt = 1'b0;
    out_word_nxt = out_word_r;
    launch_nxt = 1'b0;
    sel_mac_nxt = sel_mac_r;
    ins_nxt = ins_r;
    op_nxt = op_r;
    hit_known_nxt = hit_known_r;
    mac_key_nxt = mac_key_r;
    route_key_nxt = route_key_r;
    peer_q_nxt = peer_q_r;
    peer_set_nxt = peer_set_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = d_imm;
          out_word_nxt = d_res;
          if (d_go) begin
            launch_nxt = 1'b1;
            sel_mac_nxt = d_sel_mac;
            ins_nxt = d_ins;
            op_nxt = d_op;
            hit_known_nxt = 1'b0;
            mac_key_nxt = (in_word.kind == KIND_INBOUND) ? in_word.src_mac
                                                          : in_word.dest_mac;
            route_key_nxt = in_word.ip_addr;
            peer_q_nxt = in_word.peer_index;
          end
          // peer set edits happen right at accept
          for (int i = 0; i < SET_W; i++) begin
            if (has_peer && (in_word.peer_index == PEER_W'(i))) begin
              if (in_word.kind == KIND_ADD_PEER) peer_set_nxt[i] = 1'b1;
              if (in_word.kind == KIND_DEL_PEER) peer_set_nxt[i] = 1'b0;
            end
          end
          if (in_word.kind == KIND_CLEAR) peer_set_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (done) begin
          if (ins_r) begin
            // second pass writes the hit entry or the lowest free one
            hit_known_nxt = tok.hit;
            op_nxt = OP_INSERT;
            launch_nxt = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            out_word_nxt = '0;
            if (op_r == OP_LOOKUP) begin
              if (tok.hit) begin
                out_word_nxt.action = ACT_UNICAST;
                out_word_nxt.out_peer = tok.peer;
              end else if (sel_mac_r) begin
                out_word_nxt.action = ACT_FLOOD;
                out_word_nxt.flood_mask = flood;
              end
            end
          end
        end
      end
      ST_FILL: begin
        if (done) begin
          out_valid_nxt = 1'b1;
          out_word_nxt = '0;
          out_word_nxt.action = sel_mac_r ? ACT_LOCAL : ACT_DROP;
          out_word_nxt.table_full = !hit_known_r && !tok.claimed;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      layer2_r <= 1'b0;
      peer_set_r <= '0;
      out_valid_r <= 1'b0;
      launch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) layer2_r <= cfg_wdata;
      peer_set_r <= peer_set_nxt;
      out_valid_r <= out_valid_nxt;
      launch_r <= launch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    sel_mac_r <= sel_mac_nxt;
    ins_r <= ins_nxt;
    op_r <= op_nxt;
    hit_known_r <= hit_known_nxt;
    mac_key_r <= mac_key_nxt;
    route_key_r <= route_key_nxt;
    peer_q_r <= peer_q_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

endmodule

[rtl/lbrf_checker.sv]
// port-level checks for the forwarder, bound to the top level
// depends on lbrf_pkg and learning_bridge_and_route_forwarder
module lbrf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           busy,
  input logic           out_valid,
  input lbrf_pkg::out_t out_word
);
  import lbrf_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or strobe after reset");

  a_scan_ends_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("scan ended without a result word");

  a_mask_only_flood: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.action != ACT_FLOOD) |-> out_word.flood_mask == '0)
    else $error("flood mask set on a non-flood word");

  a_peer_only_unicast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.action != ACT_UNICAST) |-> out_word.out_peer == '0)
    else $error("peer set on a non-unicast word");

  a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.table_full |->
      (out_word.action == ACT_DROP) || (out_word.action == ACT_LOCAL))
    else $error("table full on a forwarding word");

endmodule

bind learning_bridge_and_route_forwarder lbrf_checker u_lbrf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .busy     (busy),
  .out_valid(out_valid),
  .out_word (out_word)
);

[verif/learning_bridge_and_route_forwarder_test.sv]
// self-checking test for learning_bridge_and_route_forwarder: directed and random words,
// predicted in-line and compared word by word; depends on rtl/lbrf_pkg.sv and the block rtl
module learning_bridge_and_route_forwarder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lbrf_pkg::*;

  localparam int TABLE_SIZE = 64;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;
  // longest word is a learn or set route: two passes over the chain
  localparam int SETTLE_CYCLES = 2 * TABLE_SIZE + 12;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [47:0] GROUP_MASK = 48'h01_0000_0000_00;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_word = '0;
  logic out_valid;
  out_t out_word;

  always #4 clk = ~clk;

  learning_bridge_and_route_forwarder dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word)
  );

  // shadow copy of the forwarding state
  logic        bridge_mode;
  logic        mac_live [TABLE_SIZE];
  logic [47:0] mac_addr [TABLE_SIZE];
  logic [3:0]  mac_owner [TABLE_SIZE];
  logic        route_live [TABLE_SIZE];
  logic [31:0] route_dest [TABLE_SIZE];
  logic [3:0]  route_hop [TABLE_SIZE];
  logic [15:0] peers;

  out_t pending_decisions[$];
  int fails = 0;
  int words_sent = 0;
  int words_checked = 0;
  int full_seen = 0;
  bit idle_off = 1'b0;
  longint cycles = 0;

  function automatic void wipe_tables();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      mac_live[i] = 1'b0;
      route_live[i] = 1'b0;
    end
    peers = '0;
  endfunction

  function automatic int find_mac(logic [47:0] key);
    for (int i = 0; i < TABLE_SIZE; i++)
      if (mac_live[i] && mac_addr[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_route(logic [31:0] key);
    for (int i = 0; i < TABLE_SIZE; i++)
      if (route_live[i] && route_dest[i] == key) return i;
    return -1;
  endfunction

  // learn or overwrite; returns 1 when a new key found no free entry
  function automatic logic learn_mac(logic [47:0] key, logic [3:0] owner);
    int slot;
    slot = find_mac(key);
    if (slot < 0)
      for (int i = TABLE_SIZE - 1; i >= 0; i--)
        if (!mac_live[i]) slot = i;
    if (slot < 0) return 1'b1;
    mac_live[slot] = 1'b1;
    mac_addr[slot] = key;
    mac_owner[slot] = owner;
    return 1'b0;
  endfunction

  function automatic logic learn_route(logic [31:0] key, logic [3:0] hop);
    int slot;
    slot = find_route(key);
    if (slot < 0)
      for (int i = TABLE_SIZE - 1; i >= 0; i--)
        if (!route_live[i]) slot = i;
    if (slot < 0) return 1'b1;
    route_live[slot] = 1'b1;
    route_dest[slot] = key;
    route_hop[slot] = hop;
    return 1'b0;
  endfunction

  // forwarding decision for one accepted word, updating the shadow state
  function automatic out_t decide(in_t w);
    out_t d;
    int hit;
    d = '0;
    case (w.kind)
      KIND_OUTBOUND: begin
        if (bridge_mode) begin
          if (w.frame_length >= L2_HDR_LEN) begin
            // group and broadcast frames never look up the table
            hit = (w.dest_mac & GROUP_MASK) != 0 ? -1 : find_mac(w.dest_mac);
            if (hit < 0) begin
              d.action = ACT_FLOOD;
              d.flood_mask = peers;
            end else begin
              d.action = ACT_UNICAST;
              d.out_peer = mac_owner[hit];
            end
          end
        end else if (w.frame_length >= L3_HDR_LEN && w.first_byte[7:4] == IPV4_VER) begin
          hit = find_route(w.ip_addr);
          if (hit >= 0) begin
            d.action = ACT_UNICAST;
            d.out_peer = route_hop[hit];
          end
        end
      end
      KIND_INBOUND: begin
        if (bridge_mode && w.frame_length >= SRC_MAC_END && w.peer_present)
          d.table_full = learn_mac(w.src_mac, w.peer_index);
        d.action = ACT_LOCAL;
      end
      KIND_SET_ROUTE:
        if (w.ip_addr != 0 && w.peer_present)
          d.table_full = learn_route(w.ip_addr, w.peer_index);
      KIND_DEL_ROUTE: begin
        hit = find_route(w.ip_addr);
        if (hit >= 0) route_live[hit] = 1'b0;
      end
      KIND_ADD_PEER:
        if (w.peer_present) peers[w.peer_index] = 1'b1;
      KIND_DEL_PEER:
        if (w.peer_present) begin
          // routes to the peer survive, learned MACs do not
          peers[w.peer_index] = 1'b0;
          for (int i = 0; i < TABLE_SIZE; i++)
            if (mac_live[i] && mac_owner[i] == w.peer_index) mac_live[i] = 1'b0;
        end
      KIND_CLEAR: wipe_tables();
      default: ;
    endcase
    return d;
  endfunction

  // one word to the block; called at a rising edge, returns at the accepting edge
  task automatic send_word(in_t w);
    int gap;
    if (!idle_off && $urandom_range(99) < 11) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_decisions.push_back(decide(w));
    words_sent++;
  endtask

  // drain outstanding words, then let the block settle before a register write
  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic l2);
    quiesce();
    cfg_we <= 1'b1;
    cfg_wdata <= l2;
    @(posedge clk);
    cfg_we <= 1'b0;
    bridge_mode = l2;
    @(posedge clk);
  endtask

  function automatic in_t make_word(logic [2:0] k, logic [15:0] len, logic [7:0] fb,
                                    logic [47:0] dm, logic [47:0] sm, logic [31:0] ip,
                                    logic [3:0] p, logic pp);
    in_t w;
    w.kind = k;
    w.frame_length = len;
    w.first_byte = fb;
    w.dest_mac = dm;
    w.src_mac = sm;
    w.ip_addr = ip;
    w.peer_index = p;
    w.peer_present = pp;
    return w;
  endfunction

  // small pools so lookups hit and tables can fill
  function automatic logic [47:0] pool_mac(int idx);
    return {16'h0200, 32'(idx)} ^ 48'h00ab_0000_0000;
  endfunction

  function automatic logic [31:0] pool_ip(int idx);
    return 32'h0a00_0001 + 32'(idx);
  endfunction

  // result checker: the receiver always accepts
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_decisions.size() == 0) begin
        $error("result word with no decision pending");
        fails++;
      end else begin
        want = pending_decisions.pop_front();
        words_checked++;
        if (out_word.table_full) full_seen++;
        if (out_word.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_word.action);
          fails++;
        end
        if (out_word.out_peer !== want.out_peer) begin
          $error("out_peer: expected %0d, got %0d", want.out_peer, out_word.out_peer);
          fails++;
        end
        if (out_word.flood_mask !== want.flood_mask) begin
          $error("flood_mask: expected %h, got %h", want.flood_mask, out_word.flood_mask);
          fails++;
        end
        if (out_word.table_full !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, out_word.table_full);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // routing mode: short, non-ipv4, miss, hit, route edits, peers off the set
  task automatic test_routing();
    set_mode(1'b0);
    send_word(make_word(KIND_OUTBOUND, 16'd19, 8'h45, '0, '0, 32'h0a00_0001, 4'd0, 1'b0));
    send_word(make_word(KIND_OUTBOUND, 16'hffff, 8'h65, '1, '1, 32'h0a00_0001, 4'd0, 1'b0));
    send_word(make_word(KIND_OUTBOUND, 16'd20, 8'h4f, '0, '0, 32'h0a00_0001, 4'd0, 1'b0));
    send_word(make_word(KIND_SET_ROUTE, 16'd0, 8'h00, '0, '0, 32'h0a00_0001, 4'd15, 1'b1));
    send_word(make_word(KIND_SET_ROUTE, 16'd0, 8'h00, '0, '0, 32'h0, 4'd3, 1'b1));
    send_word(make_word(KIND_SET_ROUTE, 16'd0, 8'h00, '0, '0, 32'hffff_ffff, 4'd3, 1'b0));
    send_word(make_word(KIND_OUTBOUND, 16'd20, 8'h40, '0, '0, 32'h0a00_0001, 4'd0, 1'b0));
    // overwrite in place
    send_word(make_word(KIND_SET_ROUTE, 16'd0, 8'h00, '0, '0, 32'h0a00_0001, 4'd0, 1'b1));
    send_word(make_word(KIND_OUTBOUND, 16'd20, 8'h40, '0, '0, 32'h0a00_0001, 4'd0, 1'b0));
    send_word(make_word(KIND_OUTBOUND, 16'd20, 8'h40, '0, '0, 32'hffff_ffff, 4'd0, 1'b0));
    send_word(make_word(KIND_DEL_ROUTE, 16'd0, 8'h00, '0, '0, 32'h0a00_0001, 4'd0, 1'b0));
    send_word(make_word(KIND_OUTBOUND, 16'd20, 8'h40, '0, '0, 32'h0a00_0001, 4'd0, 1'b0));
    send_word(make_word(KIND_INBOUND, 16'd0, 8'h00, '0, '0, '0, 4'd0, 1'b0));
    send_word(make_word(KIND_UNKNOWN, '1, '1, '1, '1, '1, '1, 1'b1));
  endtask

  // bridging mode: flood, learn, unicast, group bit, purge on peer removal
  task automatic test_bridging();
    set_mode(1'b1);
    send_word(make_word(KIND_ADD_PEER, '0, '0, '0, '0, '0, 4'd0, 1'b1));
    send_word(make_word(KIND_ADD_PEER, '0, '0, '0, '0, '0, 4'd15, 1'b1));
    send_word(make_word(KIND_ADD_PEER, '0, '0, '0, '0, '0, 4'd7, 1'b0));
    send_word(make_word(KIND_OUTBOUND, 16'd13, '0, 48'h0200_0000_0001, '0, '0, 4'd0, 1'b0));
    send_word(make_word(KIND_OUTBOUND, 16'd14, '0, 48'h0200_0000_0001, '0, '0, 4'd0, 1'b0));
    send_word(make_word(KIND_INBOUND, 16'd11, '0, '0, 48'h0200_0000_0001, '0, 4'd15, 1'b1));
    send_word(make_word(KIND_INBOUND, 16'd12, '0, '0, 48'h0200_0000_0001, '0, 4'd15, 1'b0));
    send_word(make_word(KIND_INBOUND, 16'd12, '0, '0, 48'h0200_0000_0001, '0, 4'd15, 1'b1));
    send_word(make_word(KIND_OUTBOUND, 16'd14, '0, 48'h0200_0000_0001, '0, '0, 4'd0, 1'b0));
    // learned group address still floods
    send_word(make_word(KIND_INBOUND, 16'd64, '0, '0, 48'hffff_ffff_ffff, '0, 4'd9, 1'b1));
    send_word(make_word(KIND_OUTBOUND, 16'd64, '0, 48'hffff_ffff_ffff, '0, '0, 4'd0, 1'b0));
    // unicast to a peer that is not in the set
    send_word(make_word(KIND_INBOUND, 16'd64, '0, '0, 48'h0, '0, 4'd9, 1'b1));
    send_word(make_word(KIND_OUTBOUND, 16'd64, '0, 48'h0, '0, '0, 4'd0, 1'b0));
    send_word(make_word(KIND_DEL_PEER, '0, '0, '0, '0, '0, 4'd15, 1'b1));
    send_word(make_word(KIND_OUTBOUND, 16'd14, '0, 48'h0200_0000_0001, '0, '0, 4'd0, 1'b0));
    send_word(make_word(KIND_DEL_PEER, '0, '0, '0, '0, '0, 4'd0, 1'b0));
    send_word(make_word(KIND_CLEAR, '0, '0, '0, '0, '0, 4'd0, 1'b0));
    // empty peer set still reports flood
    send_word(make_word(KIND_OUTBOUND, 16'd14, '0, 48'h0, '0, '0, 4'd0, 1'b0));
  endtask

  // both tables past capacity, back to back with no idling
  task automatic test_table_overflow();
    set_mode(1'b1);
    idle_off = 1'b1;
    for (int i = 0; i <= TABLE_SIZE; i++)
      send_word(make_word(KIND_INBOUND, 16'd60, '0, '0, pool_mac(i), '0, 4'(i), 1'b1));
    send_word(make_word(KIND_INBOUND, 16'd60, '0, '0, pool_mac(3), '0, 4'd12, 1'b1));
    for (int i = 0; i <= TABLE_SIZE; i++)
      send_word(make_word(KIND_SET_ROUTE, '0, '0, '0, '0, pool_ip(i), 4'(i), 1'b1));
    send_word(make_word(KIND_DEL_ROUTE, '0, '0, '0, '0, pool_ip(5), 4'd0, 1'b0));
    send_word(make_word(KIND_SET_ROUTE, '0, '0, '0, '0, pool_ip(TABLE_SIZE), 4'd1, 1'b1));
    idle_off = 1'b0;
  endtask

  function automatic in_t random_word();
    in_t w;
    int pick;
    w.kind = 3'($urandom_range(KIND_CLEAR));
    w.frame_length = 16'($urandom_range(0, 40));
    w.first_byte = $urandom_range(99) < 75 ? {IPV4_VER, 4'($urandom)} : 8'($urandom);
    w.dest_mac = pool_mac($urandom_range(0, 79));
    w.src_mac = pool_mac($urandom_range(0, 79));
    w.ip_addr = pool_ip($urandom_range(0, 79));
    w.peer_index = 4'($urandom);
    w.peer_present = $urandom_range(99) < 85;
    pick = $urandom_range(99);
    // weight toward frames, keep clear rare
    if (pick < 35) w.kind = KIND_OUTBOUND;
    else if (pick < 60) w.kind = KIND_INBOUND;
    else if (pick < 70) w.kind = KIND_SET_ROUTE;
    else if (pick < 76) w.kind = KIND_DEL_ROUTE;
    else if (pick < 85) w.kind = KIND_ADD_PEER;
    else if (pick < 90) w.kind = KIND_DEL_PEER;
    else if (pick < 91) w.kind = KIND_CLEAR;
    if ($urandom_range(99) < 8) begin
      // noise: full-width random fields including the unused kind
      w.kind = 3'($urandom);
      w.frame_length = 16'($urandom);
      w.dest_mac = {16'($urandom), 32'($urandom)};
      w.src_mac = {16'($urandom), 32'($urandom)};
      w.ip_addr = $urandom_range(99) < 20 ? 32'h0 : 32'($urandom);
    end
    if ($urandom_range(99) < 5) w.dest_mac[40] = 1'b1;
    return w;
  endfunction

  task automatic test_random(logic l2, int count);
    set_mode(l2);
    for (int n = 0; n < count; n++) begin
      idle_off = (n >= count / 3 && n < count / 2);
      send_word(random_word());
    end
    idle_off = 1'b0;
  endtask

  initial begin
    bridge_mode = 1'b0;
    wipe_tables();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_routing();
    test_bridging();
    test_table_overflow();
    test_random(1'b0, 300);
    test_random(1'b1, 400);
    test_random(1'b0, 150);
    test_random(1'b1, 150);
    quiesce();
    $display("sent %0d words, checked %0d results, %0d table-full flags",
             words_sent, words_checked, full_seen);
    $display("covered routing and bridging modes, learning, purges and table overflow");
    if (fails == 0 && pending_decisions.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fails, pending_decisions.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
